>>> rtl/lprd_pkg.sv
// Package for the length-prefixed record deframer.
// Holds the request and result struct types, phase, kind and status codes.
// No dependencies.
`timescale 1ns / 1ps

package lprd_pkg;

    localparam logic [31:0] MAX_COUNT_RESET = 32'd1000000;

    typedef enum logic [2:0] {
        PH_COUNT   = 3'd0,
        PH_PATHLEN = 3'd1,
        PH_PATH    = 3'd2,
        PH_CONTLEN = 3'd3,
        PH_CONTENT = 3'd4,
        PH_DONE    = 3'd5,
        PH_ERROR   = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PATH    = 2'd1,
        KIND_CONTENT = 2'd2,
        KIND_STATUS  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TRUNCATED = 2'd1,
        ST_BAD_COUNT = 2'd2,
        ST_UNUSED    = 2'd3
    } t_status;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_stream;
    } t_in;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  out_byte;
        logic [31:0] record_index;
        logic [15:0] path_length;
        logic [63:0] content_length;
        logic        field_end;
        t_status     status;
        logic        last;
    } t_out;

    // Results produced by one request, handed to the result queue.
    typedef struct packed {
        logic [1:0] count;
        t_out       first;
        t_out       second;
    } t_push;

endpackage

>>> rtl/length_prefixed_record_deframer.sv
// Length-prefixed record deframer: one archive byte per cycle unless stalled, results one per cycle unless stalled.
// A result is registered in the result queue when its request is accepted.
// Throughput: one request per cycle while not stalled; an end-of-stream request yields up to two results.
// Requests stall while the four-entry result queue lacks room for two results.
// Synchronous active-low reset clears the parser and the queue and sets the count limit to 1000000.
// Depends on lprd_pkg, lprd_parser and lprd_outq.
`timescale 1ns / 1ps

module length_prefixed_record_deframer
    import lprd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  t_in         i_in_data,
    output logic        o_in_stall,
    output logic        o_out_valid,
    output t_out        o_out_data,
    input  logic        i_out_stall,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [31:0] r_max_count;
    logic        room;
    logic        fire;
    t_push       push;

    assign pready     = 1'b1;
    assign o_in_stall = !room;
    assign fire       = i_in_valid && room;
    assign prdata     = (paddr[2] == 1'b0) ? r_max_count : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_count <= MAX_COUNT_RESET;
        end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
            r_max_count <= pwdata;
        end
    end

    lprd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_max_count (r_max_count),
        .i_fire      (fire),
        .i_item      (i_in_data),
        .o_push      (push)
    );

    lprd_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (o_out_valid),
        .o_data  (o_out_data),
        .i_stall (i_out_stall)
    );

endmodule

>>> rtl/lprd_parser.sv
// Parser state machine of the record deframer: one request per cycle while its fire input is high.
// Produces up to two results per request. Depends on lprd_pkg.
`timescale 1ns / 1ps

module lprd_parser
    import lprd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_max_count,
    input  logic        i_fire,
    input  t_in         i_item,
    output t_push       o_push
);

    t_phase      r_phase,  n_phase;
    logic [2:0]  r_cnt,    n_cnt;
    logic [63:0] r_shift,  n_shift;
    logic [31:0] r_total,  n_total;
    logic [31:0] r_cur,    n_cur;
    logic [63:0] r_left,   n_left;
    logic [15:0] r_plen,   n_plen;
    logic        r_err,    n_err;

    logic [63:0] shift_in;
    logic [63:0] left_dec;
    logic [31:0] cur_inc;
    logic        item_v;
    t_out        item_res;
    t_out        stat_res;
    logic [7:0]  b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_COUNT;
            r_cnt   <= '0;
            r_shift <= '0;
            r_total <= '0;
            r_cur   <= '0;
            r_left  <= '0;
            r_plen  <= '0;
            r_err   <= 1'b0;
        end else if (i_fire) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_shift <= n_shift;
            r_total <= n_total;
            r_cur   <= n_cur;
            r_left  <= n_left;
            r_plen  <= n_plen;
            r_err   <= n_err;
        end
    end

    always_comb begin
        b        = i_item.data_byte;
        shift_in = r_shift;
        for (int i = 0; i < 8; i++) begin
            if (r_cnt == 3'(i)) begin
                shift_in[8*i +: 8] = r_shift[8*i +: 8] | b;
            end
        end
        left_dec = r_left - 64'd1;
        cur_inc  = r_cur + 32'd1;

        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_shift  = r_shift;
        n_total  = r_total;
        n_cur    = r_cur;
        n_left   = r_left;
        n_plen   = r_plen;
        n_err    = r_err;
        item_v   = 1'b0;
        item_res = '0;

        case (r_phase)
            PH_COUNT: begin
                if (r_cnt == 3'd3) begin
                    n_total = shift_in[31:0];
                    n_shift = '0;
                    n_cnt   = '0;
                    if (shift_in[31:0] > i_max_count) begin
                        n_err   = 1'b1;
                        n_phase = PH_ERROR;
                    end else begin
                        n_phase = (shift_in[31:0] == 32'd0) ? PH_DONE : PH_PATHLEN;
                    end
                end else begin
                    n_shift = shift_in;
                    n_cnt   = r_cnt + 3'd1;
                end
            end
            PH_PATHLEN: begin
                if (r_cnt == 3'd1) begin
                    n_plen  = shift_in[15:0];
                    n_left  = {48'd0, shift_in[15:0]};
                    n_shift = '0;
                    n_cnt   = '0;
                    n_phase = (shift_in[15:0] != 16'd0) ? PH_PATH : PH_CONTLEN;
                end else begin
                    n_shift = shift_in;
                    n_cnt   = r_cnt + 3'd1;
                end
            end
            PH_PATH: begin
                item_v                = 1'b1;
                item_res.kind         = KIND_PATH;
                item_res.out_byte     = b;
                item_res.record_index = r_cur;
                item_res.field_end    = (r_left == 64'd1);
                n_left                = left_dec;
                if (left_dec == 64'd0) begin
                    n_phase = PH_CONTLEN;
                end
            end
            PH_CONTLEN: begin
                if (r_cnt == 3'd7) begin
                    // The eighth byte completes the content length.
                    n_left                  = shift_in;
                    n_shift                 = '0;
                    n_cnt                   = '0;
                    item_v                  = 1'b1;
                    item_res.kind           = KIND_HEADER;
                    item_res.record_index   = r_cur;
                    item_res.path_length    = r_plen;
                    item_res.content_length = shift_in;
                    if (shift_in == 64'd0) begin
                        n_cur   = cur_inc;
                        n_phase = (cur_inc == r_total) ? PH_DONE : PH_PATHLEN;
                    end else begin
                        n_phase = PH_CONTENT;
                    end
                end else begin
                    n_shift = shift_in;
                    n_cnt   = r_cnt + 3'd1;
                end
            end
            PH_CONTENT: begin
                item_v                = 1'b1;
                item_res.kind         = KIND_CONTENT;
                item_res.out_byte     = b;
                item_res.record_index = r_cur;
                item_res.field_end    = (r_left == 64'd1);
                n_left                = left_dec;
                if (left_dec == 64'd0) begin
                    n_cur   = cur_inc;
                    n_phase = (cur_inc == r_total) ? PH_DONE : PH_PATHLEN;
                end
            end
            default: begin
            end
        endcase

        stat_res              = '0;
        stat_res.kind         = KIND_STATUS;
        stat_res.record_index = n_cur;
        stat_res.last         = 1'b1;
        if (n_err) begin
            stat_res.status = ST_BAD_COUNT;
        end else if (n_phase == PH_DONE) begin
            stat_res.status = ST_OK;
        end else begin
            stat_res.status = ST_TRUNCATED;
        end
        item_res.last = !i_item.end_of_stream;

        // End of stream returns the parser to its reset state.
        if (i_item.end_of_stream) begin
            n_phase = PH_COUNT;
            n_cnt   = '0;
            n_shift = '0;
            n_total = '0;
            n_cur   = '0;
            n_left  = '0;
            n_plen  = '0;
            n_err   = 1'b0;
        end

        o_push = '0;
        if (item_v) begin
            o_push.first  = item_res;
            o_push.second = stat_res;
            o_push.count  = i_item.end_of_stream ? 2'd2 : 2'd1;
        end else begin
            o_push.first  = stat_res;
            o_push.count  = i_item.end_of_stream ? 2'd1 : 2'd0;
        end
        if (!i_fire) begin
            o_push.count = 2'd0;
        end
    end

endmodule

>>> rtl/lprd_outq.sv
// Four-entry result queue of the record deframer.
// Takes up to two results per cycle, delivers one per cycle unless stalled. Depends on lprd_pkg.
`timescale 1ns / 1ps

module lprd_outq
    import lprd_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    output logic  o_room,
    output logic  o_valid,
    output t_out  o_data,
    input  logic  i_stall
);

    t_out       r_mem [4];
    logic [1:0] r_wr, n_wr;
    logic [1:0] r_rd, n_rd;
    logic [2:0] r_cnt, n_cnt;
    logic       pop;
    logic [1:0] wr_next;

    assign o_valid = (r_cnt != 3'd0);
    assign o_data  = r_mem[r_rd];
    // Room for the two results an end-of-stream request can produce.
    assign o_room  = (r_cnt <= 3'd2);
    assign pop     = o_valid && !i_stall;
    assign wr_next = r_wr + 2'd1;

    always_comb begin
        n_wr  = r_wr + i_push.count;
        n_rd  = pop ? r_rd + 2'd1 : r_rd;
        n_cnt = r_cnt + {1'b0, i_push.count} - {2'b00, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_next] <= i_push.second;
        end
    end

endmodule
